[src/swq_pkg.sv]
// package for the semaphore wait-queue table
// types, constants and request/status codes shared by all modules
`timescale 1ns / 1ps
package swq_pkg;
    localparam int MaxProcs = 16;
    localparam int IdxW = $clog2(MaxProcs);
    localparam int KeyW = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;
    localparam logic [1:0] REQ_OUT    = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOFREE   = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture request
        logic scan_clr;   // reset scan index
        logic scan_step;  // advance scan index
        logic walk_start; // cur <= head of proc_desc
        logic walk_step;  // prev <= cur, cur <= link
        logic do_insert;  // commit insert
        logic do_pop;     // commit remove/peek
        logic do_unlink;  // commit unlink of cur
        logic set_res;    // latch result with status
        logic [1:0] res_status;
    } swq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] req;
        logic       key_zero;
        logic       proc_wait;
        logic       scan_last;
        logic       found;     // key found during scan
        logic       free_seen; // free descriptor seen
        logic       cur_is_p;
        logic       cur_is_tail;
        logic       desc_ok;
    } swq_stat_t;
endpackage

[src/swq_datapath.sv]
// datapath of the semaphore wait-queue table: descriptor and process arrays
// depends on swq_pkg
`timescale 1ns / 1ps
module swq_datapath
    import swq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          in_req,
    input  logic [KeyW-1:0]     in_key,
    input  logic [IdxW-1:0]     in_proc,
    input  swq_cmd_t            cmd,
    output swq_stat_t           stat,
    output logic [1:0]          res_status,
    output logic [IdxW-1:0]     res_proc,
    output logic                res_valid
);
    logic [MaxProcs-1:0] active_reg, active_next;
    logic [MaxProcs-1:0] waiting_reg, waiting_next;
    logic [KeyW-1:0] key_arr_reg [MaxProcs];
    logic [IdxW-1:0] head_reg [MaxProcs];
    logic [IdxW-1:0] tail_reg [MaxProcs];
    logic [IdxW-1:0] link_reg [MaxProcs];
    logic [IdxW-1:0] pdesc_reg [MaxProcs];

    logic [1:0]      req_reg;
    logic [KeyW-1:0] key_reg;
    logic [IdxW-1:0] proc_reg;
    logic [IdxW-1:0] scan_reg;
    logic [IdxW-1:0] hit_reg;
    logic            found_reg;
    logic [IdxW-1:0] free_reg;
    logic            free_seen_reg;
    logic [IdxW-1:0] cur_reg, prev_reg;
    logic            has_prev_reg;
    logic [1:0]      rstat_reg;
    logic [IdxW-1:0] rproc_reg;
    logic            rvalid_reg;

    logic            scan_hit;
    logic [IdxW-1:0] d_pd;
    logic [IdxW-1:0] hd;

    assign scan_hit = active_reg[scan_reg] && key_arr_reg[scan_reg] == key_reg;
    assign d_pd = pdesc_reg[proc_reg];
    assign hd = head_reg[hit_reg];

    assign stat.req = req_reg;
    assign stat.key_zero = (key_reg == '0);
    assign stat.proc_wait = waiting_reg[proc_reg];
    assign stat.scan_last = (scan_reg == IdxW'(MaxProcs - 1));
    assign stat.found = found_reg;
    assign stat.free_seen = free_seen_reg;
    assign stat.cur_is_p = (cur_reg == proc_reg);
    assign stat.cur_is_tail = (cur_reg == tail_reg[d_pd]);
    assign stat.desc_ok = active_reg[d_pd];

    assign res_status = rstat_reg;
    assign res_proc = rproc_reg;
    assign res_valid = rvalid_reg;

    always_comb
    begin
        active_next = active_reg;
        waiting_next = waiting_reg;
        if (cmd.do_insert)
        begin
            waiting_next[proc_reg] = 1'b1;
            if (!found_reg)
                active_next[free_reg] = 1'b1;
        end
        if (cmd.do_pop && req_reg == REQ_REMOVE)
        begin
            waiting_next[hd] = 1'b0;
            if (hd == tail_reg[hit_reg])
                active_next[hit_reg] = 1'b0;
        end
        if (cmd.do_unlink)
        begin
            waiting_next[proc_reg] = 1'b0;
            if (!has_prev_reg && cur_reg == tail_reg[d_pd])
                active_next[d_pd] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            waiting_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            waiting_reg <= waiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req;
            key_reg <= in_key;
            proc_reg <= in_proc;
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
            found_reg <= 1'b0;
            free_seen_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (scan_hit && !found_reg)
            begin
                found_reg <= 1'b1;
                hit_reg <= scan_reg;
            end
            if (!active_reg[scan_reg] && !free_seen_reg)
            begin
                free_seen_reg <= 1'b1;
                free_reg <= scan_reg;
            end
        end
        if (cmd.walk_start)
        begin
            cur_reg <= head_reg[d_pd];
            has_prev_reg <= 1'b0;
        end
        else if (cmd.walk_step)
        begin
            prev_reg <= cur_reg;
            cur_reg <= link_reg[cur_reg];
            has_prev_reg <= 1'b1;
        end
        if (cmd.do_insert)
        begin
            link_reg[proc_reg] <= proc_reg;
            pdesc_reg[proc_reg] <= found_reg ? hit_reg : free_reg;
            if (found_reg)
            begin
                link_reg[tail_reg[hit_reg]] <= proc_reg;
                tail_reg[hit_reg] <= proc_reg;
            end
            else
            begin
                key_arr_reg[free_reg] <= key_reg;
                head_reg[free_reg] <= proc_reg;
                tail_reg[free_reg] <= proc_reg;
            end
        end
        if (cmd.do_pop && req_reg == REQ_REMOVE && hd != tail_reg[hit_reg])
            head_reg[hit_reg] <= link_reg[hd];
        if (cmd.do_unlink)
        begin
            if (!has_prev_reg)
            begin
                if (cur_reg != tail_reg[d_pd])
                    head_reg[d_pd] <= link_reg[cur_reg];
            end
            else
            begin
                link_reg[prev_reg] <= link_reg[cur_reg];
                if (cur_reg == tail_reg[d_pd])
                    tail_reg[d_pd] <= prev_reg;
            end
        end
        if (cmd.set_res)
        begin
            rstat_reg <= cmd.res_status;
            if (cmd.do_pop)
            begin
                rvalid_reg <= 1'b1;
                rproc_reg <= hd;
            end
            else if (cmd.do_unlink)
            begin
                rvalid_reg <= 1'b1;
                rproc_reg <= proc_reg;
            end
            else
            begin
                rvalid_reg <= 1'b0;
                rproc_reg <= '0;
            end
        end
    end
endmodule

[src/swq_ctrl.sv]
// controller state machine of the semaphore wait-queue table
// depends on swq_pkg
`timescale 1ns / 1ps
module swq_ctrl
    import swq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  swq_stat_t stat,
    output swq_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [IdxW:0] steps_reg, steps_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        steps_next = steps_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.scan_clr = 1'b1;
                cmd.walk_start = 1'b1;
                steps_next = '0;
                if (stat.req == REQ_INSERT)
                begin
                    if (stat.key_zero || stat.proc_wait)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_status = ST_REJECT;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SCAN;
                end
                else if (stat.req == REQ_OUT)
                begin
                    if (!stat.proc_wait || !stat.desc_ok)
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_WALK;
                end
                else if (stat.key_zero)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.set_res = 1'b1;
                state_next = S_OUT;
                if (stat.req == REQ_INSERT)
                begin
                    if (stat.found || stat.free_seen)
                    begin
                        cmd.do_insert = 1'b1;
                        cmd.res_status = ST_DONE;
                    end
                    else
                        cmd.res_status = ST_NOFREE;
                end
                else if (stat.found)
                begin
                    cmd.do_pop = 1'b1;
                    cmd.res_status = ST_DONE;
                end
                else
                    cmd.res_status = ST_NOTFOUND;
            end
            S_WALK:
            begin
                if (stat.cur_is_p)
                begin
                    cmd.do_unlink = 1'b1;
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_DONE;
                    state_next = S_OUT;
                end
                else if (stat.cur_is_tail || steps_reg == (IdxW+1)'(MaxProcs - 1))
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
        end
    end

    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.do_insert, cmd.do_pop, cmd.do_unlink}) <= 1)
        else $error("more than one commit in a cycle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_res_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_res |=> state_reg == S_OUT)
        else $error("result latched without output");
endmodule

[src/semaphore_wait_queue_table.sv]
// top level of the semaphore wait-queue table
// depends on swq_pkg, swq_ctrl, swq_datapath
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata: req_type[1:0], key[33:2], proc_id[37:34]
// m_axis   out  m_axis_tvalid/tready      tdata: status[1:0], result_proc[5:2], result_valid[6]
//
// one item in flight; insert, remove and peek scan the keys of all descriptors,
// remove-given walks the queue of the owning descriptor, one link per cycle
// a rejected insert, a null key or a process that is not waiting goes straight to output
// reset clears descriptor active bits and process waiting bits; other tables need none
// the result holds in an output register until taken
`timescale 1ns / 1ps
module semaphore_wait_queue_table
    import swq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // req_type, key, proc_id, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // status, result_proc, result_valid, zero pad
);
    swq_cmd_t cmd;
    swq_stat_t stat;
    logic [1:0] res_status;
    logic [IdxW-1:0] res_proc;
    logic res_valid;

    swq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    swq_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_req(s_axis_tdata[1:0]),
        .in_key(s_axis_tdata[33:2]),
        .in_proc(s_axis_tdata[37:34]),
        .cmd(cmd), .stat(stat),
        .res_status(res_status), .res_proc(res_proc), .res_valid(res_valid)
    );

    // output word packing
    assign m_axis_tdata = {1'b0, res_valid, res_proc, res_status};
endmodule

[verif/semaphore_wait_queue_table_tb.sv]
// testbench for the semaphore wait-queue table
// self-checking: a scoreboard class predicts every result of the block
// depends on swq_pkg and semaphore_wait_queue_table
`timescale 1ns / 1ps
module semaphore_wait_queue_table_tb;
    import swq_pkg::*;

    // shadow of the descriptor pool and the process wait queues
    class sem_table_scoreboard;
        bit              active [MaxProcs];
        logic [KeyW-1:0] dkey   [MaxProcs];
        int              head   [MaxProcs];
        int              tail   [MaxProcs];
        int              link   [MaxProcs];
        bit              waiting[MaxProcs];
        int              owner  [MaxProcs];
        logic [6:0]      pending_results[$];
        int              errors;

        function void clear();
            for (int i = 0; i < MaxProcs; i++)
            begin
                active[i] = 0;
                waiting[i] = 0;
            end
            errors = 0;
        endfunction

        function int find_desc(logic [KeyW-1:0] k);
            if (k == 0)
                return MaxProcs;
            for (int i = 0; i < MaxProcs; i++)
                if (active[i] && dkey[i] == k)
                    return i;
            return MaxProcs;
        endfunction

        // predict the result of one accepted request and update the shadow
        function void note_request(logic [1:0] req, logic [KeyW-1:0] k, int p);
            logic [1:0] st;
            int         rp;
            bit         rv;
            int         d;
            int         h;
            int         prev;
            int         cur;
            st = ST_NOTFOUND;
            rp = 0;
            rv = 0;
            if (req == REQ_INSERT)
            begin
                if (k == 0 || waiting[p])
                    st = ST_REJECT;
                else
                begin
                    d = find_desc(k);
                    if (d < MaxProcs)
                    begin
                        link[tail[d]] = p;
                        tail[d] = p;
                        st = ST_DONE;
                    end
                    else
                    begin
                        d = 0;
                        while (d < MaxProcs && active[d])
                            d++;
                        if (d >= MaxProcs)
                            st = ST_NOFREE;
                        else
                        begin
                            active[d] = 1;
                            dkey[d] = k;
                            head[d] = p;
                            tail[d] = p;
                            st = ST_DONE;
                        end
                    end
                    if (st == ST_DONE)
                    begin
                        link[p] = p;
                        waiting[p] = 1;
                        owner[p] = d;
                    end
                end
            end
            else if (req == REQ_REMOVE || req == REQ_PEEK)
            begin
                d = find_desc(k);
                if (d < MaxProcs)
                begin
                    h = head[d];
                    if (req == REQ_REMOVE)
                    begin
                        waiting[h] = 0;
                        if (h == tail[d])
                            active[d] = 0;
                        else
                            head[d] = link[h];
                    end
                    st = ST_DONE;
                    rp = h;
                    rv = 1;
                end
            end
            else if (waiting[p] && active[owner[p]])
            begin
                // walk the queue of the owning descriptor
                d = owner[p];
                prev = MaxProcs;
                cur = head[d];
                for (int s = 0; s < MaxProcs; s++)
                begin
                    if (cur == p)
                    begin
                        if (prev == MaxProcs)
                        begin
                            if (p == tail[d])
                                active[d] = 0;
                            else
                                head[d] = link[p];
                        end
                        else
                        begin
                            link[prev] = link[p];
                            if (p == tail[d])
                                tail[d] = prev;
                        end
                        waiting[p] = 0;
                        st = ST_DONE;
                        rp = p;
                        rv = 1;
                        break;
                    end
                    if (cur == tail[d])
                        break;
                    prev = cur;
                    cur = link[cur];
                end
            end
            pending_results.push_back({rv, rp[3:0], st});
        endfunction

        function void check_result(logic [7:0] got);
            logic [6:0] exp;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got[1:0] !== exp[1:0])
            begin
                $error("status: expected %0d actual %0d", exp[1:0], got[1:0]);
                errors++;
            end
            if (got[5:2] !== exp[5:2])
            begin
                $error("result_proc: expected %0d actual %0d", exp[5:2], got[5:2]);
                errors++;
            end
            if (got[6] !== exp[6])
            begin
                $error("result_valid: expected %0d actual %0d", exp[6], got[6]);
                errors++;
            end
            if (got[7] !== 1'b0)
            begin
                $error("pad: expected 0 actual %0d", got[7]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // req_type, key, proc_id, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // status, result_proc, result_valid, zero pad

    sem_table_scoreboard sb;
    bit                  calm;       // no idling on either side while set
    bit                  stim_done;

    // small key set so inserts collide onto shared queues
    logic [KeyW-1:0] key_pool[6] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'h1234_5678, 32'h7FFF_FFFF, 32'hA5A5_5A5A};

    semaphore_wait_queue_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // send one request item; gaps before it at random unless calm
    // called at a falling edge; valid stays high into a back-to-back item
    task automatic send_request(logic [1:0] req, logic [KeyW-1:0] k, logic [3:0] p);
        while (!calm && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {2'b00, p, k, req};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req, k, int'(p));
        @(negedge clk);
    endtask

    // random request biased toward the known keys and busy queues
    task automatic send_random();
        int              r;
        logic [KeyW-1:0] k;
        r = $urandom_range(99);
        if (r < 8)
            k = $urandom();
        else if (r < 12)
            k = '0;
        else
            k = key_pool[$urandom_range(5)];
        r = $urandom_range(99);
        if (r < 45)
            send_request(REQ_INSERT, k, 4'($urandom_range(15)));
        else if (r < 65)
            send_request(REQ_REMOVE, k, 4'($urandom_range(15)));
        else if (r < 80)
            send_request(REQ_PEEK, k, 4'($urandom_range(15)));
        else
            send_request(REQ_OUT, $urandom(), 4'($urandom_range(15)));
    endtask

    // result side: stall at random, check every accepted item
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 28);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    initial
    begin
        sb = new();
        sb.clear();
        calm = 0;
        stim_done = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: every request kind, null key, duplicate, pool exhaustion
        send_request(REQ_REMOVE, 32'h1, 4'd0);        // empty table
        send_request(REQ_PEEK, 32'h0, 4'd0);          // null key
        send_request(REQ_OUT, 32'h0, 4'd15);          // not waiting
        send_request(REQ_INSERT, 32'h0, 4'd3);        // null key rejected
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 4'd15);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 4'd7);
        send_request(REQ_INSERT, 32'h1, 4'd15);       // already blocked
        send_request(REQ_PEEK, 32'hFFFF_FFFF, 4'd0);
        send_request(REQ_OUT, 32'h0, 4'd15);          // middle of queue
        send_request(REQ_OUT, 32'h0, 4'd7);           // tail of queue
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 4'd0); // frees descriptor
        send_request(REQ_PEEK, 32'hFFFF_FFFF, 4'd0);
        // fill all sixteen descriptors
        for (int i = 0; i < MaxProcs; i++)
            send_request(REQ_INSERT, 32'h100 + i, i[3:0]);
        // nobody left to insert, so free one head then try a new key
        send_request(REQ_REMOVE, 32'h100, 4'd0);
        send_request(REQ_INSERT, 32'h5000, 4'd0);     // takes lowest free
        for (int i = 0; i < MaxProcs; i++)
            send_request(REQ_OUT, 32'h0, i[3:0]);

        // random: a calm stretch in the middle
        for (int n = 0; n < 1350; n++)
        begin
            calm = (n >= 500 && n < 700);
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        calm = 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

[filelist.f]
src/swq_pkg.sv
src/swq_datapath.sv
src/swq_ctrl.sv
src/semaphore_wait_queue_table.sv
verif/semaphore_wait_queue_table_tb.sv
